[hdl/tss_pkg.sv]
// Shared types and character constants for the Turtle statement splitter.
package tss_pkg;

  typedef enum logic [2:0] {
    MODE_FREE       = 3'd0,
    MODE_ANGLES     = 3'd1,
    MODE_QUOTES     = 3'd2,
    MODE_LONG       = 3'd3,
    MODE_COMMENT    = 3'd4,
    MODE_ONE_QUOTE  = 3'd5,
    MODE_TWO_QUOTES = 3'd6
  } mode_t;

  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_WS_LO   = 8'h01;
  localparam logic [7:0] CH_WS_HI   = 8'h20;

  localparam logic [1:0] LONG_CLOSE_RUN = 2'd3;

  // result of one scanned item
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       stmt_end;
    logic       abandoned;
  } tss_res_t;

endpackage

[hdl/tss_lexer.sv]
// Lexical state of the splitter and the per-item result logic.
module tss_lexer (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_input,
  output tss_pkg::tss_res_t res
);
  import tss_pkg::*;

  mode_t      mode, mode_next;
  logic [1:0] quote_run, quote_run_next;
  logic       backslash_odd, backslash_odd_next;
  logic       skipping_lead, skipping_lead_next;
  logic       stmt_open, stmt_open_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_FREE;
      quote_run     <= 2'd0;
      backslash_odd <= 1'b0;
      skipping_lead <= 1'b1;
      stmt_open     <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      quote_run     <= quote_run_next;
      backslash_odd <= backslash_odd_next;
      skipping_lead <= skipping_lead_next;
      stmt_open     <= stmt_open_next;
    end
  end

  always_comb begin
    logic       esc;
    logic       use_free;
    logic       stmt_end;
    logic [1:0] run_inc;
    mode_next          = mode;
    quote_run_next     = quote_run;
    backslash_odd_next = backslash_odd;
    skipping_lead_next = skipping_lead;
    stmt_open_next     = stmt_open;
    esc                = backslash_odd;
    use_free           = 1'b0;
    stmt_end           = 1'b0;
    run_inc            = quote_run + 2'd1;
    res                = '0;

    if (end_of_input) begin
      // abandon marker only if something was started; scanner starts over
      res.valid          = stmt_open;
      res.abandoned      = 1'b1;
      mode_next          = MODE_FREE;
      quote_run_next     = 2'd0;
      backslash_odd_next = 1'b0;
      skipping_lead_next = 1'b1;
      stmt_open_next     = 1'b0;
    end else begin
      backslash_odd_next = (data_byte == CH_BSLASH) ? ~esc : 1'b0;
      if (!(skipping_lead && data_byte >= CH_WS_LO && data_byte <= CH_WS_HI)) begin
        skipping_lead_next = 1'b0;
        stmt_open_next     = 1'b1;
        case (mode)
          MODE_ONE_QUOTE: begin
            mode_next = (data_byte == CH_QUOTE) ? MODE_TWO_QUOTES : MODE_QUOTES;
          end
          MODE_TWO_QUOTES: begin
            if (data_byte == CH_QUOTE) begin
              mode_next      = MODE_LONG;
              quote_run_next = 2'd0;
            end else begin
              use_free = 1'b1;
            end
          end
          MODE_ANGLES: begin
            if (data_byte == CH_GT) mode_next = MODE_FREE;
          end
          MODE_QUOTES: begin
            if (data_byte == CH_QUOTE && !esc) mode_next = MODE_FREE;
          end
          MODE_LONG: begin
            if (data_byte == CH_QUOTE) begin
              // an escaped quote cannot begin the closing run
              if (quote_run != 2'd0 || !esc) begin
                if (run_inc == LONG_CLOSE_RUN) begin
                  quote_run_next = 2'd0;
                  mode_next      = MODE_FREE;
                end else begin
                  quote_run_next = run_inc;
                end
              end
            end else begin
              quote_run_next = 2'd0;
            end
          end
          MODE_COMMENT: begin
            if (data_byte == CH_NL) mode_next = MODE_FREE;
          end
          default: begin
            use_free = 1'b1;
          end
        endcase

        if (use_free) begin
          mode_next = MODE_FREE;
          case (data_byte)
            CH_DOT:   stmt_end = 1'b1;
            CH_LT:    mode_next = MODE_ANGLES;
            CH_QUOTE: mode_next = esc ? MODE_FREE : MODE_ONE_QUOTE;
            CH_HASH:  mode_next = MODE_COMMENT;
            default:  mode_next = MODE_FREE;
          endcase
        end

        if (stmt_end) begin
          skipping_lead_next = 1'b1;
          stmt_open_next     = 1'b0;
        end

        res.valid    = 1'b1;
        res.data     = data_byte;
        res.stmt_end = stmt_end;
      end
    end
  end

endmodule

[hdl/turtle_statement_splitter.sv]
// Top level of the Turtle statement splitter: input register, lexer, result register.
//
//  channel | tdata        | tlast         | tuser
//  s_*     | data_byte    | end_of_input  | -
//  m_*     | out_byte     | statement_end | abandoned
//
// One item per cycle sustained while m_tready does not stall; an accepted item passes
// the input register, then the result register behind the lexer logic, to m_*.
// Dropped leading whitespace and an end of input with no open statement
// give no result item.
// rst is synchronous and returns the scanner to free mode, skipping whitespace.
// A stall on m_tready holds both registers; s_tready follows it combinationally.
module turtle_statement_splitter (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_input
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // statement_end
  output logic       m_tuser    // [0] abandoned
);
  import tss_pkg::*;

  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;
  logic       advance;
  tss_res_t   res;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  tss_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .step         (in_valid && advance),
    .data_byte    (in_data),
    .end_of_input (in_last),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && res.valid) begin
      m_tdata <= res.data;
      m_tlast <= res.stmt_end;
      m_tuser <= res.abandoned;
    end
  end

endmodule

[hdl/tss_checker.sv]
// Port-level checks for the statement splitter, bound to the top level.
module tss_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);
  import tss_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_end_xor_abandon: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tlast && m_tuser))
    else $error("item marked both statement end and abandoned");

  a_abandon_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'd0)
    else $error("abandon item carries a byte");

  a_end_is_dot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == CH_DOT)
    else $error("statement end on a byte other than a dot");

endmodule

bind turtle_statement_splitter tss_checker u_tss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

[test/turtle_statement_splitter_tb.sv]
// Self-checking testbench for the Turtle statement splitter: predicts results and checks the stream.
module turtle_statement_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tss_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1000;
  localparam int TAIL_CYCLES = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       stmt_end;
    logic       abandoned;
  } split_result_t;

  // Scanner state mirror plus the queue of results still owed by the block.
  class splitter_scoreboard;
    mode_t         lex_mode;
    logic [1:0]    quote_run;
    bit            bslash_odd;
    bit            skipping_ws;
    bit            stmt_open;
    split_result_t expected_q[$];
    int            errors;
    int            produced;

    function new();
      restart();
      errors   = 0;
      produced = 0;
    endfunction

    function void restart();
      lex_mode    = MODE_FREE;
      quote_run   = 2'd0;
      bslash_odd  = 1'b0;
      skipping_ws = 1'b1;
      stmt_open   = 1'b0;
    endfunction

    function void push_result(logic [7:0] d, logic last, logic user);
      split_result_t r;
      r.data      = d;
      r.stmt_end  = last;
      r.abandoned = user;
      expected_q.push_back(r);
      produced++;
    endfunction

    // Free-mode byte; returns 1 when it ends the statement.
    function bit free_mode_byte(logic [7:0] b, bit esc);
      case (b)
        CH_DOT: return 1'b1;
        CH_LT: lex_mode = MODE_ANGLES;
        CH_QUOTE: if (!esc) lex_mode = MODE_ONE_QUOTE;
        CH_HASH: lex_mode = MODE_COMMENT;
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_item(logic [7:0] b, logic eoi);
      bit esc;
      bit done;
      if (eoi) begin
        if (stmt_open) push_result(8'h00, 1'b0, 1'b1);
        restart();
        return;
      end
      esc = bslash_odd;
      bslash_odd = (b == CH_BSLASH) ? !esc : 1'b0;
      if (skipping_ws && b >= CH_WS_LO && b <= CH_WS_HI) return;
      skipping_ws = 1'b0;
      stmt_open   = 1'b1;
      done        = 1'b0;
      case (lex_mode)
        MODE_ONE_QUOTE: begin
          if (b == CH_QUOTE) lex_mode = MODE_TWO_QUOTES;
          else lex_mode = MODE_QUOTES;
        end
        MODE_TWO_QUOTES: begin
          if (b == CH_QUOTE) begin
            lex_mode  = MODE_LONG;
            quote_run = 2'd0;
          end else begin
            lex_mode = MODE_FREE;
            done     = free_mode_byte(b, esc);
          end
        end
        MODE_ANGLES: if (b == CH_GT) lex_mode = MODE_FREE;
        MODE_QUOTES: if (b == CH_QUOTE && !esc) lex_mode = MODE_FREE;
        MODE_LONG: begin
          if (b == CH_QUOTE) begin
            // an escaped quote cannot start the closing run
            if (quote_run != 2'd0 || !esc) begin
              quote_run = quote_run + 2'd1;
              if (quote_run >= LONG_CLOSE_RUN) begin
                quote_run = 2'd0;
                lex_mode  = MODE_FREE;
              end
            end
          end else begin
            quote_run = 2'd0;
          end
        end
        MODE_COMMENT: if (b == CH_NL) lex_mode = MODE_FREE;
        default: begin
          lex_mode = MODE_FREE;
          done     = free_mode_byte(b, esc);
        end
      endcase
      if (done) begin
        skipping_ws = 1'b1;
        stmt_open   = 1'b0;
      end
      push_result(b, done, 1'b0);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [7:0] d, logic last, logic user);
      split_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result with none pending: byte %02h end %b abandoned %b",
                         d, last, user));
        return;
      end
      e = expected_q.pop_front();
      if (d !== e.data)
        report($sformatf("out_byte %02h, predicted %02h", d, e.data));
      if (last !== e.stmt_end)
        report($sformatf("statement_end %b, predicted %b (byte %02h)", last, e.stmt_end, e.data));
      if (user !== e.abandoned)
        report($sformatf("abandoned %b, predicted %b", user, e.abandoned));
    endtask
  endclass

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  splitter_scoreboard sb = new();
  bit idle_on = 1'b1;
  int quiet_cycles = 0;
  int stall_left = 0;

  turtle_statement_splitter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] ws_byte();
    return 8'($urandom_range(CH_WS_LO, CH_WS_HI));
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 6))
      0: return CH_DOT;
      1: return CH_LT;
      2: return CH_GT;
      3: return CH_QUOTE;
      4: return CH_HASH;
      5: return CH_NL;
      default: return CH_BSLASH;
    endcase
  endfunction

  // non-whitespace byte with no lexical meaning
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 255));
    while (b == CH_DOT || b == CH_LT || b == CH_GT || b == CH_QUOTE ||
           b == CH_HASH || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] any_byte_but(logic [7:0] excl);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == excl);
    return b;
  endfunction

  // receiver side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // accepted items on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
      if (s_tvalid && s_tready) sb.note_item(s_tdata, s_tlast);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [7:0] b, logic eoi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = eoi;
    do @(posedge clk);
    while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // hold the sender until the block has caught up
  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  // one statement built from well-formed tokens with random content
  task automatic send_stmt();
    int kind;
    int len;
    repeat ($urandom_range(0, 2)) send_byte(ws_byte());
    repeat ($urandom_range(1, 5)) begin
      kind = $urandom_range(0, 5);
      len  = $urandom_range(0, 4);
      case (kind)
        0: repeat (len + 1) send_byte(plain_byte());
        1: begin
          send_byte(CH_LT);
          repeat (len) send_byte(any_byte_but(CH_GT));
          send_byte(CH_GT);
        end
        2: begin
          send_byte(CH_QUOTE);
          repeat (len + 1) begin
            case ($urandom_range(0, 3))
              0: send_byte(plain_byte());
              1: begin
                send_byte(CH_BSLASH);
                send_byte(8'($urandom_range(0, 255)));
              end
              2: send_byte(special_byte() == CH_DOT ? CH_DOT : CH_HASH);
              default: begin
                send_byte(CH_BSLASH);
                send_byte(CH_QUOTE);
              end
            endcase
          end
          send_byte(CH_QUOTE);
        end
        3: begin
          repeat (3) send_byte(CH_QUOTE);
          repeat (len) begin
            case ($urandom_range(0, 4))
              0: send_byte(plain_byte());
              1: begin
                send_byte(CH_BSLASH);
                send_byte(8'($urandom_range(0, 255)));
              end
              2: begin
                send_byte(CH_QUOTE);
                send_byte(plain_byte());
              end
              3: begin
                repeat (2) send_byte(CH_QUOTE);
                send_byte(plain_byte());
              end
              default: send_byte($urandom_range(0, 1) ? CH_DOT : CH_NL);
            endcase
          end
          repeat (3) send_byte(CH_QUOTE);
        end
        4: begin
          send_byte(CH_HASH);
          repeat (len) send_byte(any_byte_but(CH_NL));
          send_byte(CH_NL);
        end
        default: repeat (len + 1) send_byte(ws_byte());
      endcase
    end
    if ($urandom_range(0, 9) == 0) send_eoi();
    else send_byte(CH_DOT);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 3))
        0: send_byte(8'($urandom_range(0, 255)));
        1: send_byte(special_byte());
        2: send_byte(ws_byte());
        default: send_byte($urandom_range(0, 1) ? 8'h00 : 8'hFF);
      endcase
    end
    if ($urandom_range(0, 1)) send_eoi();
  endtask

  task automatic run_directed();
    send_eoi();                                                  // nothing open
    send_byte(CH_WS_HI); send_byte(CH_WS_LO); send_byte(8'h00);  // NUL opens
    send_byte(CH_LT); send_byte(CH_DOT); send_byte(CH_GT);
    send_byte(CH_GT); send_byte(CH_NL);                          // stray closers
    send_byte(CH_QUOTE); send_byte(CH_QUOTE); send_byte(CH_DOT); // "" then end
    send_byte(8'hFF); send_byte(CH_QUOTE); send_byte(CH_BSLASH);
    send_byte(CH_QUOTE); send_byte(CH_QUOTE);
    send_byte(CH_HASH); send_byte(CH_DOT); send_byte(CH_NL);
    repeat (3) send_byte(CH_QUOTE);
    send_byte(CH_BSLASH); send_byte(CH_QUOTE);                   // escaped in long
    repeat (4) send_byte(CH_QUOTE);                              // close, then one more
    send_byte(CH_DOT);
    send_eoi();                                                  // abandon
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    run_directed();
    drain();
    while (sb.produced < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 19))
        0, 1, 2: send_noise();
        3: send_eoi();
        4: drain();
        default: send_stmt();
      endcase
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
